FILE: sv/piir_pkg.sv
// shared types, constants and coefficient table of the polyphase iir half-band filter
`timescale 1ns / 1ps

package piir_pkg;

    localparam int NUM_SECTIONS = 6;
    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 18;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [COEF_W-1:0]          coef_t;

    typedef enum logic
    {
        PATH_A = 1'b0,
        PATH_B = 1'b1
    } piir_path_t;

    // token handed from cell to cell
    typedef struct packed
    {
        logic       valid;
        piir_path_t path;
        sample_t    data;
    } piir_tok_t;

    // allpass coefficients, unsigned q0.18; sections past the sixth are pure delays
    function automatic coef_t coef_value(input piir_path_t path, input int unsigned idx);
        coef_t ca;
        coef_t cb;
        case (idx)
            0:
            begin
                ca = coef_t'(9616);
                cb = coef_t'(35795);
            end
            1:
            begin
                ca = coef_t'(71993);
                cb = coef_t'(110923);
            end
            2:
            begin
                ca = coef_t'(147089);
                cb = coef_t'(177613);
            end
            3:
            begin
                ca = coef_t'(201783);
                cb = coef_t'(220172);
            end
            4:
            begin
                ca = coef_t'(233901);
                cb = coef_t'(244198);
            end
            5:
            begin
                ca = coef_t'(252207);
                cb = coef_t'(258950);
            end
            default:
            begin
                ca = '0;
                cb = '0;
            end
        endcase
        return (path == PATH_B) ? cb : ca;
    endfunction

endpackage

FILE: sv/piir_cell.sv
// one second-order allpass section holding history for both paths
`timescale 1ns / 1ps

module piir_cell
    import piir_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  coef_t     coef_a,
    input  coef_t     coef_b,
    input  piir_tok_t tok_in,
    output piir_tok_t tok_out
);

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = SAMPLE_W + COEF_W + 2;
    localparam int RES_W  = PROD_W - COEF_W;
    localparam int SUM_W  = RES_W + 1;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) <<< (COEF_W - 1);
    localparam logic signed [SUM_W-1:0]  SAT_HI =
        {{(SUM_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SAT_LO = ~SAT_HI;

    sample_t x1_reg [2];
    sample_t x2_reg [2];
    sample_t y1_reg [2];
    sample_t y2_reg [2];
    piir_tok_t tok_reg;

    sample_t                   x2_sel;
    sample_t                   y2_sel;
    coef_t                     coef_sel;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  rnd;
    logic signed [RES_W-1:0]   res;
    logic signed [SUM_W-1:0]   acc;
    sample_t                   y_next;

    always_comb
    begin
        x2_sel   = x2_reg[tok_in.path];
        y2_sel   = y2_reg[tok_in.path];
        coef_sel = (tok_in.path == PATH_B) ? coef_b : coef_a;
        diff     = DIFF_W'(tok_in.data) - DIFF_W'(y2_sel);
        prod     = PROD_W'(diff) * PROD_W'($signed({1'b0, coef_sel}));
        rnd      = prod + ROUND_BIAS;
        res      = rnd[PROD_W-1:COEF_W];
        acc      = SUM_W'(x2_sel) + SUM_W'(res);
        if (acc > SAT_HI)
        begin
            y_next = SAT_HI[SAMPLE_W-1:0];
        end
        else if (acc < SAT_LO)
        begin
            y_next = SAT_LO[SAMPLE_W-1:0];
        end
        else
        begin
            y_next = acc[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            for (int p = 0; p < 2; p++)
            begin
                x1_reg[p] <= '0;
                x2_reg[p] <= '0;
                y1_reg[p] <= '0;
                y2_reg[p] <= '0;
            end
        end
        else
        begin
            tok_reg.valid <= tok_in.valid;
            tok_reg.path  <= tok_in.path;
            tok_reg.data  <= y_next;
            if (tok_in.valid)
            begin
                x2_reg[tok_in.path] <= x1_reg[tok_in.path];
                x1_reg[tok_in.path] <= tok_in.data;
                y2_reg[tok_in.path] <= y1_reg[tok_in.path];
                y1_reg[tok_in.path] <= y_next;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: sv/polyphase_iir_halfband_filter.sv
// top level: input control, chain of allpass cells and output buffering
`timescale 1ns / 1ps
// sample_out shows a result once the path a token has passed every cell and the output register
// a new input beat is taken only after the path b token, which trails the path a token, has
//   left the cell chain, and only while the spare output slot is empty
// a finished result waits in an output register, with one spare slot behind it
// reset (rst_n low, asynchronous) clears all section history and the held path b result

module polyphase_iir_halfband_filter
    import piir_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  sample_t sample_in,
    output logic    out_valid,
    input  logic    out_ready,
    output sample_t sample_out
);

    // cell chain; entry 0 is the injection point
    piir_tok_t chain [NUM_SECTIONS + 1];

    logic    busy_reg,  busy_next;
    logic    inj_b_reg, inj_b_next;
    sample_t hold_reg,  hold_next;
    sample_t prevb_reg, prevb_next;
    logic    outv_reg,  outv_next;
    sample_t outd_reg,  outd_next;
    logic    pendv_reg, pendv_next;
    sample_t pendd_reg, pendd_next;

    logic                    in_beat;
    logic                    out_beat;
    logic                    a_done;
    logic                    b_done;
    logic signed [SAMPLE_W:0] pair_sum;
    sample_t                 half;

    assign in_ready = !busy_reg && !pendv_reg;
    assign in_beat  = in_valid && in_ready;
    assign out_beat = outv_reg && out_ready;

    // path a token enters on the beat, path b token enters the cycle after
    always_comb
    begin
        chain[0].valid = in_beat || inj_b_reg;
        chain[0].path  = inj_b_reg ? PATH_B : PATH_A;
        chain[0].data  = inj_b_reg ? hold_reg : sample_in;
    end

    for (genvar g = 0; g < NUM_SECTIONS; g++)
    begin : g_cell
        piir_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .coef_a  (coef_value(PATH_A, g)),
            .coef_b  (coef_value(PATH_B, g)),
            .tok_in  (chain[g]),
            .tok_out (chain[g + 1])
        );
    end

    assign a_done = chain[NUM_SECTIONS].valid && (chain[NUM_SECTIONS].path == PATH_A);
    assign b_done = chain[NUM_SECTIONS].valid && (chain[NUM_SECTIONS].path == PATH_B);

    // half of path a now plus path b from the previous sample, floor rounding
    assign pair_sum = (SAMPLE_W + 1)'(chain[NUM_SECTIONS].data) + (SAMPLE_W + 1)'(prevb_reg);
    assign half     = pair_sum[SAMPLE_W:1];

    always_comb
    begin
        busy_next  = busy_reg;
        inj_b_next = in_beat;
        hold_next  = in_beat ? sample_in : hold_reg;
        prevb_next = b_done ? chain[NUM_SECTIONS].data : prevb_reg;
        outv_next  = outv_reg;
        outd_next  = outd_reg;
        pendv_next = pendv_reg;
        pendd_next = pendd_reg;

        if (in_beat)
        begin
            busy_next = 1'b1;
        end
        else if (b_done)
        begin
            busy_next = 1'b0;
        end

        // output register frees up: refill from the spare slot first
        if (!outv_reg || out_beat)
        begin
            if (pendv_reg)
            begin
                outv_next  = 1'b1;
                outd_next  = pendd_reg;
                pendv_next = 1'b0;
            end
            else if (a_done)
            begin
                outv_next = 1'b1;
                outd_next = half;
            end
            else
            begin
                outv_next = 1'b0;
            end
        end
        else if (a_done)
        begin
            pendv_next = 1'b1;
            pendd_next = half;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            inj_b_reg <= 1'b0;
            prevb_reg <= '0;
            outv_reg  <= 1'b0;
            pendv_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            inj_b_reg <= inj_b_next;
            prevb_reg <= prevb_next;
            outv_reg  <= outv_next;
            pendv_reg <= pendv_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg  <= hold_next;
        outd_reg  <= outd_next;
        pendd_reg <= pendd_next;
    end

    assign out_valid  = outv_reg;
    assign sample_out = outd_reg;

endmodule

FILE: sv/piir_check.sv
// port-level checker for the polyphase iir half-band filter and its bind
`timescale 1ns / 1ps

module piir_check
    import piir_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input sample_t sample_in,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t sample_out
);

    // an accepted beat closes the input; only the start of its run down the chain is checked
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("input reopened too early after a beat");

    // a result only appears while an item is in flight or buffered
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared with no item in flight");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
        else $error("stalled output beat changed");

    // a waiting input beat holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(sample_in)))
        else $error("waiting input beat changed");

    // a new input beat is never taken in the cycle right after another
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !(in_valid && in_ready))
        else $error("two input beats in consecutive cycles");

endmodule

bind polyphase_iir_halfband_filter piir_check u_piir_check (.*);

FILE: verif/testbench.sv
// testbench for the polyphase iir half-band filter: directed and random samples against a predictor
`timescale 1ns / 1ps

module testbench
    import piir_pkg::*;
();

    localparam int MAX_SECTIONS = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 16;

    localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    // allpass coefficients in q0.18, path a then path b; zero past the sixth section
    localparam longint COEF_PATH_A [MAX_SECTIONS] = '{
        9616, 71993, 147089, 201783, 233901, 252207, 0, 0, 0, 0, 0, 0
    };
    localparam longint COEF_PATH_B [MAX_SECTIONS] = '{
        35795, 110923, 177613, 220172, 244198, 258950, 0, 0, 0, 0, 0, 0
    };

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    sample_t sample_in = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    sample_t sample_out;

    // predictor state: two-sample history of each section, indexed by path
    longint  sec_x1 [2][MAX_SECTIONS];
    longint  sec_x2 [2][MAX_SECTIONS];
    longint  sec_y1 [2][MAX_SECTIONS];
    longint  sec_y2 [2][MAX_SECTIONS];
    longint  held_path_b;

    sample_t expected_samples [$];
    int      fail_count = 0;
    int      cycle_count = 0;
    bit      idle_enable = 1'b0;
    int      out_stall_left = 0;

    polyphase_iir_halfband_filter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint clamp_sample(input longint v);
        if (v > SAMPLE_MAX)
            return SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            return SAMPLE_MIN;
        return v;
    endfunction

    // one sample through the chain of allpass sections of one path
    function automatic longint allpass_cascade(input piir_path_t path, input longint x);
        longint v;
        longint d;
        longint r;
        longint y;
        longint c;
        int     p;
        p = int'(path);
        v = x;
        for (int i = 0; i < NUM_SECTIONS; i++)
        begin
            c = (path == PATH_B) ? COEF_PATH_B[i] : COEF_PATH_A[i];
            d = v - sec_y2[p][i];
            // round half up on the q0.18 product, arithmetic shift floors
            r = (d * c + (64'sd1 <<< (COEF_W - 1))) >>> COEF_W;
            y = clamp_sample(sec_x2[p][i] + r);
            sec_x2[p][i] = sec_x1[p][i];
            sec_x1[p][i] = v;
            sec_y2[p][i] = sec_y1[p][i];
            sec_y1[p][i] = y;
            v = y;
        end
        return v;
    endfunction

    // expected output for one input beat, advances the predictor state
    function automatic sample_t halfband_predict(input sample_t x);
        longint a_res;
        longint half;
        a_res = allpass_cascade(PATH_A, longint'(x));
        // path a now plus path b of the previous sample, halved with floor
        half = (a_res + held_path_b) >>> 1;
        held_path_b = allpass_cascade(PATH_B, longint'(x));
        return sample_t'(half);
    endfunction

    // one input beat; valid stays high into the next beat unless a gap is taken
    task automatic send_sample(input sample_t v);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        expected_samples.push_back(halfband_predict(v));
        in_valid  <= 1'b1;
        sample_in <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending and wait until every expected beat has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_extremes();
        sample_t pattern [$];
        pattern = '{
            sample_t'(0), sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN),
            sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN), sample_t'(1), sample_t'(-1),
            sample_t'(24'h555555), sample_t'(24'hAAAAAA)
        };
        foreach (pattern[i])
            send_sample(pattern[i]);
        // full-scale impulse and its ring-down
        send_sample(sample_t'(SAMPLE_MAX));
        repeat (5) send_sample(sample_t'(0));
        // negative full-scale step, drives sections into saturation
        repeat (6) send_sample(sample_t'(SAMPLE_MIN));
        repeat (4) send_sample(sample_t'(SAMPLE_MAX));
    endtask

    // one random sample: noise, small signal, extremes or a smooth walk
    task automatic send_random_sample(inout longint walk);
        int      kind;
        sample_t v;
        kind = $urandom_range(0, 9);
        if (kind < 3)
            v = sample_t'($urandom());
        else if (kind < 5)
            v = sample_t'($urandom_range(0, 512) - 256);
        else if (kind < 6)
        begin
            case ($urandom_range(0, 3))
                0:       v = sample_t'(SAMPLE_MAX);
                1:       v = sample_t'(SAMPLE_MIN);
                2:       v = sample_t'(0);
                default: v = sample_t'(-1);
            endcase
        end
        else
        begin
            // audio-like: bounded random walk
            walk = clamp_sample(walk + longint'($urandom_range(0, 400000)) - 200000);
            v = sample_t'(walk);
        end
        send_sample(v);
    endtask

    task automatic test_random_with_idling();
        longint walk;
        walk = 0;
        idle_enable = 1'b1;
        for (int n = 0; n < 400; n++)
        begin
            send_random_sample(walk);
            // sender holds off once until the filter has emptied
            if (n == 200)
                drain_results();
        end
    endtask

    task automatic test_back_to_back();
        longint walk;
        walk = 0;
        idle_enable = 1'b0;
        for (int n = 0; n < 100; n++)
            send_random_sample(walk);
    endtask

    // receiver: random stall bursts while idling is on
    always @(posedge clk)
    begin
        if (out_stall_left > 0)
        begin
            out_stall_left <= out_stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            out_stall_left <= $urandom_range(0, 12);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // every output beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample_out beat with no expectation: actual %0d", sample_out);
                fail_count++;
            end
            else if (sample_out !== expected_samples[0])
            begin
                $error("sample_out mismatch: expected %0d, actual %0d",
                       expected_samples[0], sample_out);
                fail_count++;
                void'(expected_samples.pop_front());
            end
            else
                void'(expected_samples.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("polyphase_iir_halfband_filter test failed");
            $finish;
        end
    end

    initial
    begin
        for (int p = 0; p < 2; p++)
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                sec_x1[p][i] = 0;
                sec_x2[p][i] = 0;
                sec_y1[p][i] = 0;
                sec_y2[p][i] = 0;
            end
        held_path_b = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_random_with_idling();
        test_back_to_back();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("polyphase_iir_halfband_filter test passed");
        else
            $display("polyphase_iir_halfband_filter test failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/piir_pkg.sv
sv/piir_cell.sv
sv/polyphase_iir_halfband_filter.sv
sv/piir_check.sv
verif/testbench.sv
